### rtl/core/swld_pkg.sv
// Package for the sync word deframer: phase and route codes, the result record,
// the header constants and the command to route mapping.
// Used by every module of the deframer; it depends on nothing.
package swld_pkg;

	localparam int unsigned DEFAULT_BUFFER_BYTES = 1048576;
	localparam int unsigned HEADER_BYTES         = 12;
	localparam int unsigned CFG_W                = 20;
	localparam logic [CFG_W-1:0] MAX_BODY_RESET  = 20'd1048564;
	localparam logic [31:0] SYNC_WORD            = 32'h55AA77CC;

	localparam logic [31:0] SCREEN_ID   = 32'd1;
	localparam logic [31:0] MOUSE_ID    = 32'd2;
	localparam logic [31:0] KEYBOARD_ID = 32'd3;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_CMD  = 2'd1,
		PH_LEN  = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ROUTE_SCREEN   = 2'd0,
		ROUTE_MOUSE    = 2'd1,
		ROUTE_KEYBOARD = 2'd2,
		ROUTE_UNKNOWN  = 2'd3
	} route_t;

	typedef struct packed {
		route_t      route;
		logic [31:0] command_id;
		logic [7:0]  body_byte;
		logic        has_byte;
		logic        last;
		logic        length_error;
	} result_t;

	function automatic route_t route_of(input logic [31:0] cmd);
		route_t r;
		begin
			if (cmd == SCREEN_ID) begin
				r = ROUTE_SCREEN;
			end else if (cmd == MOUSE_ID) begin
				r = ROUTE_MOUSE;
			end else if (cmd == KEYBOARD_ID) begin
				r = ROUTE_KEYBOARD;
			end else begin
				r = ROUTE_UNKNOWN;
			end
			return r;
		end
	endfunction

endpackage

### rtl/core/sync_word_length_deframer.sv
// Top level of the sync word, length prefixed deframer: configuration register,
// parser and output buffer. Depends on swld_pkg, swld_parser and swld_out_buf.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    data_byte
//   out      from block out_valid / out_stall  route, command_id, body_byte,
//                                              has_byte, last, length_error
//   cfg      to block   cfg_valid / cfg_ready  cfg_data (max_body_len)
//
// One byte is taken per cycle while in_stall is low; it passes the input and output registers.
// The rate is set by the single input register feeding the framing state machine.
// Reset clears the state machine, the buffers and sets max_body_len to 1048564.
// A stall on out holds the output word; one more word fits the skid entry before
// in_stall rises. cfg_ready is always high.
module sync_word_length_deframer #(
	parameter int unsigned BUFFER_BYTES = swld_pkg::DEFAULT_BUFFER_BYTES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 route,
	output logic signed [31:0]         command_id,
	output logic [7:0]                 body_byte,
	output logic                       has_byte,
	output logic                       last,
	output logic                       length_error,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [swld_pkg::CFG_W-1:0] cfg_data
);

	logic [swld_pkg::CFG_W-1:0] max_body_len_q;
	logic                       push_valid;
	swld_pkg::result_t          push_data;
	logic                       buf_ready;
	swld_pkg::result_t          out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_len_q <= swld_pkg::MAX_BODY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_body_len_q <= cfg_data;
		end
	end

	swld_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.max_body_len(max_body_len_q),
		.push_valid  (push_valid),
		.push_data   (push_data),
		.buf_ready   (buf_ready)
	);

	swld_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_data (push_data),
		.buf_ready (buf_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign route        = out_data.route;
	assign command_id   = out_data.command_id;
	assign body_byte    = out_data.body_byte;
	assign has_byte     = out_data.has_byte;
	assign last         = out_data.last;
	assign length_error = out_data.length_error;

endmodule

### rtl/core/swld_parser.sv
// Input register and framing state machine: sync hunt, header collection,
// length check and body byte counting. Depends on swld_pkg.
module swld_parser #(
	parameter int unsigned BUFFER_BYTES = swld_pkg::DEFAULT_BUFFER_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic [swld_pkg::CFG_W-1:0]  max_body_len,
	output logic                        push_valid,
	output swld_pkg::result_t           push_data,
	input  logic                        buf_ready
);

	localparam logic [31:0] CAP = 32'(BUFFER_BYTES - swld_pkg::HEADER_BYTES);
	localparam int unsigned CFG_MAX = (1 << swld_pkg::CFG_W) - 1;
	localparam int unsigned LIMIT_MAX = (BUFFER_BYTES - swld_pkg::HEADER_BYTES < CFG_MAX) ?
		BUFFER_BYTES - swld_pkg::HEADER_BYTES : CFG_MAX;
	localparam int unsigned CNT_W = $clog2(LIMIT_MAX + 1);

	logic                  in_valid_s1;
	logic [7:0]            data_byte_s1;

	swld_pkg::phase_t      phase_q, phase_d;
	logic [31:0]           window_q, window_d;
	logic [1:0]            idx_q, idx_d;
	logic [31:0]           cmd_q, cmd_d;
	logic [23:0]           len_q, len_d;
	logic [CNT_W-1:0]      remain_q, remain_d;

	logic                  res_valid;
	swld_pkg::result_t     res;
	logic [31:0]           shifted;
	logic [31:0]           full_len;
	logic [31:0]           limit;
	logic                  advance;
	logic                  accept;

	assign accept     = in_valid && !in_stall;
	assign advance    = in_valid_s1 && (!res_valid || buf_ready);
	assign in_stall   = in_valid_s1 && !advance;
	assign push_valid = in_valid_s1 && res_valid && buf_ready;
	assign push_data  = res;

	assign shifted  = {data_byte_s1, window_q[31:8]};
	assign full_len = {data_byte_s1, len_q};
	assign limit    = ({12'd0, max_body_len} > CAP) ? CAP : {12'd0, max_body_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (accept) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= swld_pkg::PH_HUNT;
			window_q <= '0;
			idx_q    <= '0;
			cmd_q    <= '0;
			len_q    <= '0;
			remain_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			idx_q    <= idx_d;
			cmd_q    <= cmd_d;
			len_q    <= len_d;
			remain_q <= remain_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		window_d  = window_q;
		idx_d     = idx_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		remain_d  = remain_q;
		res_valid = 1'b0;
		res.route        = swld_pkg::route_of(cmd_q);
		res.command_id   = cmd_q;
		res.body_byte    = '0;
		res.has_byte     = 1'b0;
		res.last         = 1'b0;
		res.length_error = 1'b0;
		case (phase_q)
			swld_pkg::PH_HUNT: begin
				window_d = shifted;
				if (shifted == swld_pkg::SYNC_WORD) begin
					window_d = '0;
					phase_d  = swld_pkg::PH_CMD;
					idx_d    = '0;
				end
			end
			swld_pkg::PH_CMD: begin
				case (idx_q)
					2'd0: cmd_d[7:0]   = data_byte_s1;
					2'd1: cmd_d[15:8]  = data_byte_s1;
					2'd2: cmd_d[23:16] = data_byte_s1;
					default: cmd_d[31:24] = data_byte_s1;
				endcase
				if (idx_q == 2'd3) begin
					idx_d   = '0;
					phase_d = swld_pkg::PH_LEN;
				end else begin
					idx_d = idx_q + 2'd1;
				end
			end
			swld_pkg::PH_LEN: begin
				if (idx_q != 2'd3) begin
					case (idx_q)
						2'd0: len_d[7:0]   = data_byte_s1;
						2'd1: len_d[15:8]  = data_byte_s1;
						default: len_d[23:16] = data_byte_s1;
					endcase
					idx_d = idx_q + 2'd1;
				end else if (full_len[31] || full_len > limit) begin
					res_valid        = 1'b1;
					res.last         = 1'b1;
					res.length_error = 1'b1;
					phase_d  = swld_pkg::PH_HUNT;
					idx_d    = '0;
					window_d = '0;
					remain_d = '0;
				end else if (full_len == 32'd0) begin
					// A header with no body still yields one empty word.
					res_valid = 1'b1;
					res.last  = 1'b1;
					phase_d  = swld_pkg::PH_HUNT;
					idx_d    = '0;
					window_d = '0;
					remain_d = '0;
				end else begin
					remain_d = full_len[CNT_W-1:0];
					idx_d    = '0;
					phase_d  = swld_pkg::PH_BODY;
				end
			end
			swld_pkg::PH_BODY: begin
				if (remain_q == '0) begin
					phase_d  = swld_pkg::PH_HUNT;
					idx_d    = '0;
					window_d = '0;
				end else if (remain_q == CNT_W'(1)) begin
					res_valid     = 1'b1;
					res.body_byte = data_byte_s1;
					res.has_byte  = 1'b1;
					res.last      = 1'b1;
					phase_d  = swld_pkg::PH_HUNT;
					idx_d    = '0;
					window_d = '0;
					remain_d = '0;
				end else begin
					res_valid     = 1'b1;
					res.body_byte = data_byte_s1;
					res.has_byte  = 1'b1;
					remain_d      = remain_q - CNT_W'(1);
				end
			end
			default: begin
				phase_d = swld_pkg::PH_HUNT;
			end
		endcase
	end

	// The body count never sits at zero: the length check keeps empty bodies out.
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == swld_pkg::PH_BODY) |-> (remain_q != '0))
		else $error("body phase with zero bytes remaining");

	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != swld_pkg::PH_HUNT) |-> (window_q == '0))
		else $error("sync window not clear outside hunt");

	a_sync_found: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == swld_pkg::PH_HUNT && shifted == swld_pkg::SYNC_WORD)
		|=> (phase_q == swld_pkg::PH_CMD && idx_q == 2'd0))
		else $error("sync word match did not start header");

	a_no_result_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == swld_pkg::PH_HUNT || phase_q == swld_pkg::PH_CMD) |-> !res_valid)
		else $error("result raised during hunt or command bytes");

endmodule

### rtl/core/swld_out_buf.sv
// Output register with one skid entry, so the parser keeps moving while a
// finished word waits downstream. Depends on swld_pkg.
module swld_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  swld_pkg::result_t push_data,
	output logic              buf_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output swld_pkg::result_t out_data
);

	logic              out_valid_q;
	swld_pkg::result_t out_data_q;
	logic              skid_valid_q;
	swld_pkg::result_t skid_data_q;
	logic              out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign buf_ready = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push_valid;
			end
		end else if (push_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push_valid) begin
				out_data_q <= push_data;
			end
		end else if (push_valid) begin
			skid_data_q <= push_data;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_push_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !skid_valid_q)
		else $error("word pushed into a full buffer");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_stall) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry did not move to the output register");

endmodule
